/* sv/u2u_pkg.sv */
// Shared types, constants and helpers for the UTF-8 to UTF-16 decoder.
`default_nettype none
package u2u_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE     = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE     = 16'hDC00;
  localparam logic [30:0] SUPP_BASE        = 31'h0001_0000;
  localparam logic [30:0] SUPP_LIMIT       = 31'h0010_FFFF;

  typedef enum logic [1:0] {
    STAT_UNIT     = 2'd0,
    STAT_END_OK   = 2'd1,
    STAT_END_FAIL = 2'd2
  } status_t;

  // Work token passed from the front to the back: one per byte with results.
  typedef struct packed {
    logic [1:0]  n_units;   // code units carried: 0, 1 or 2
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        has_end;   // an end-of-string result follows the units
    logic        end_fail;
  } tok_t;

  // Smallest value allowed for a sequence of the given length.
  function automatic logic [30:0] min_value(input logic [2:0] seq_len);
    logic [30:0] r;
    case (seq_len)
      3'd3:    r = 31'h0000_0800;
      3'd4:    r = 31'h0001_0000;
      3'd5:    r = 31'h0020_0000;
      3'd6,
      3'd7:    r = 31'h0400_0000;
      default: r = 31'h0000_0080;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/u2u_front.sv */
// Front end: accepts UTF-8 bytes, tracks sequence state, builds work tokens.
`default_nettype none
module u2u_front
  import u2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_string,
  output logic            push,
  output tok_t            push_tok
);

  logic [2:0]  pend_r, pend_nxt;
  logic [2:0]  seqlen_r, seqlen_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic        failed_r, failed_nxt;
  logic [2:0]  lead_n;
  logic [30:0] value;
  logic [30:0] offs;
  tok_t        tok;

  always_comb begin
    if (!byte_in[6])      lead_n = 3'd1;
    else if (!byte_in[5]) lead_n = 3'd2;
    else if (!byte_in[4]) lead_n = 3'd3;
    else if (!byte_in[3]) lead_n = 3'd4;
    else if (!byte_in[2]) lead_n = 3'd5;
    else if (!byte_in[1]) lead_n = 3'd6;
    else                  lead_n = 3'd7;
  end

  always_comb begin
    pend_nxt   = pend_r;
    seqlen_nxt = seqlen_r;
    acc_nxt    = acc_r;
    failed_nxt = failed_r;
    tok        = '0;
    value      = '0;
    offs       = '0;
    if (!failed_r) begin
      if (pend_r == 3'd0) begin
        if (!byte_in[7]) begin
          tok.n_units = 2'd1;
          tok.unit0   = {8'h00, byte_in};
        end else if (lead_n == 3'd1 || lead_n == 3'd7) begin
          failed_nxt = 1'b1;
        end else begin
          case (lead_n)
            3'd2:    acc_nxt = {26'd0, byte_in[4:0]};
            3'd3:    acc_nxt = {27'd0, byte_in[3:0]};
            3'd4:    acc_nxt = {28'd0, byte_in[2:0]};
            3'd5:    acc_nxt = {29'd0, byte_in[1:0]};
            default: acc_nxt = {30'd0, byte_in[0]};
          endcase
          seqlen_nxt = lead_n;
          pend_nxt   = lead_n - 3'd1;
        end
      end else if (byte_in[7:6] != 2'b10) begin
        failed_nxt = 1'b1;
      end else begin
        acc_nxt  = {acc_r[24:0], byte_in[5:0]};
        pend_nxt = pend_r - 3'd1;
        if (pend_r == 3'd1) begin
          value = acc_nxt;
          // Replace overlong forms and the two noncharacters.
          if (value < min_value(seqlen_r) || value == 31'h0000_FFFE
              || value == 31'h0000_FFFF) begin
            value = {15'd0, REPLACEMENT_CHAR};
          end
          if (value > SUPP_LIMIT) begin
            failed_nxt = 1'b1;
          end else if (value >= SUPP_BASE) begin
            offs        = value - SUPP_BASE;
            tok.n_units = 2'd2;
            tok.unit0   = HI_SURR_BASE + {6'd0, offs[19:10]};
            tok.unit1   = LO_SURR_BASE + {6'd0, offs[9:0]};
          end else begin
            tok.n_units = 2'd1;
            tok.unit0   = value[15:0];
          end
          acc_nxt    = '0;
          seqlen_nxt = '0;
        end
      end
      if (end_of_string && pend_nxt != 3'd0) failed_nxt = 1'b1;
    end
    if (end_of_string) begin
      tok.has_end  = 1'b1;
      tok.end_fail = failed_nxt;
      pend_nxt     = '0;
      seqlen_nxt   = '0;
      acc_nxt      = '0;
      failed_nxt   = 1'b0;
    end
  end

  assign push     = in_valid && in_ready && (tok.n_units != 2'd0 || tok.has_end);
  assign push_tok = tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      seqlen_r <= '0;
      acc_r    <= '0;
      failed_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      pend_r   <= pend_nxt;
      seqlen_r <= seqlen_nxt;
      acc_r    <= acc_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/u2u_queue.sv */
// Short token queue between the front end and the back end.
`default_nettype none
module u2u_queue
  import u2u_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire tok_t push_tok,
  input  wire logic pop,
  output tok_t      head_tok,
  output logic      full,
  output logic      empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  tok_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full     = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_tok = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sv/u2u_back.sv */
// Back end: expands tokens into result transactions and keeps the unit count.
`default_nettype none
module u2u_back
  import u2u_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire tok_t        head_tok,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      code_unit,
  output status_t          status,
  output logic [31:0]      units_total,
  output logic             run_last
);

  logic [1:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, sel_cnt;
  logic                   out_valid_r;
  logic [15:0]            unit_r;
  status_t                status_r;
  logic [31:0]            total_r;
  logic                   last_r;
  logic                   load;
  logic                   is_unit, is_last;
  logic [1:0]             n_items;
  logic [15:0]            unit_sel;
  status_t                status_sel;
  logic [31:0]            total_clamped;

  assign load    = (!out_valid_r || out_ready) && !empty;
  assign n_items = head_tok.n_units + {1'b0, head_tok.has_end};
  assign is_unit = (phase_r < head_tok.n_units);
  assign is_last = (phase_r == n_items - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    unit_sel   = (phase_r == 2'd0) ? head_tok.unit0 : head_tok.unit1;
    status_sel = STAT_UNIT;
    cnt_nxt    = cnt_r;
    sel_cnt    = cnt_r;
    phase_nxt  = is_last ? 2'd0 : phase_r + 2'd1;
    if (is_unit) begin
      // Saturate the count at its maximum.
      if (!(&cnt_r)) cnt_nxt = cnt_r + 1'b1;
      sel_cnt = cnt_nxt;
    end else begin
      unit_sel   = '0;
      status_sel = head_tok.end_fail ? STAT_END_FAIL : STAT_END_OK;
      cnt_nxt    = '0;
    end
  end

  generate
    if (COUNT_WIDTH > 32) begin : g_wide
      assign total_clamped = (|sel_cnt[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : sel_cnt[31:0];
    end else begin : g_narrow
      assign total_clamped = 32'(sel_cnt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r   <= unit_sel;
      status_r <= status_sel;
      total_r  <= total_clamped;
      last_r   <= is_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign code_unit   = unit_r;
  assign status      = status_r;
  assign units_total = total_r;
  assign run_last    = last_r;

endmodule
`default_nettype wire

/* sv/utf8_to_utf16_decoder_core.sv */
// Top level of the UTF-8 to UTF-16 decoder: front end, token queue, back end.
//
// Usage:
//   The input stream carries one UTF-8 byte per transaction in in_tdata, with
//   in_tlast marking the final byte of a string. The output stream carries
//   one result per transaction: a UTF-16 code unit and the running unit count
//   in out_tdata, the result kind in out_tuser (code unit, end ok, end
//   failed) and out_tlast on the last result caused by one input byte.
//   A byte's token enters the token queue, then its first result moves into the
//   output register. Throughput: one byte per cycle while in_tready is high.
//   The output register emits one result per cycle while out_tready is high,
//   so a byte that yields a surrogate pair or a pair plus an end result holds
//   the output for each result in turn; the four-entry token queue absorbs
//   such bursts and in_tready drops only when it fills.
//   Reset clears the sequence state, the failure flag, the unit counter, the
//   queue and the output valid flag; the block is ready the cycle after.
//   When the receiver stalls, the held result stays stable on the output,
//   the queue fills behind it and then the input is stalled in turn.
//   The end result of each string returns all decoding state to reset values.
`default_nettype none
module utf8_to_utf16_decoder_core
  import u2u_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        in_tlast,   // end_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] code_unit, [47:16] units_total
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast   // run_last
);

  tok_t        push_tok, head_tok;
  logic        push, pop, full, empty;
  logic [15:0] code_unit;
  logic [31:0] units_total;
  status_t     status;

  // Accept a byte whenever the queue has room for its token.
  assign in_tready = !full;

  u2u_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .byte_in       (in_tdata),
    .end_of_string (in_tlast),
    .push          (push),
    .push_tok      (push_tok)
  );

  u2u_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .full     (full),
    .empty    (empty)
  );

  u2u_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_tok    (head_tok),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .code_unit   (code_unit),
    .status      (status),
    .units_total (units_total),
    .run_last    (out_tlast)
  );

  // Pack the result fields onto the stream.
  assign out_tdata = {units_total, code_unit};
  assign out_tuser = status;

endmodule
`default_nettype wire
